FILE: rtl/assert_macros.svh
// Assertion macros for the activity table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/cidat_pkg.sv
// Types and constants of the CAN identifier activity table.
// Depends on nothing; used by every module of the block but cidat_ram.
package cidat_pkg;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_NOTE    = 2'd1,
    OP_TICK    = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_QMISS     = 3'd4,
    ST_TICK_DONE = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_UPD,
    S_RESP_RD,
    S_RESP,
    S_TICK_RD,
    S_TICK_DIV,
    S_TICK_WR,
    S_OUT
  } state_e;

  localparam int unsigned MaxLen    = 8;
  localparam int unsigned RateScale = 1000;
  localparam int unsigned DivBits   = 42;

  // Controller to datapath commands.
  typedef struct packed {
    logic ld_in;
    logic clr_idx;
    logic inc_idx;
    logic rd_en;
    logic sel_found;
    logic sel_new;
    logic cap_match;
    logic wr_upd;
    logic resp_cap;
    logic div_start;
    logic wr_tick;
    logic out_load;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic match;
    logic idx_last;
    logic idx_at_used;
    logic full;
    logic div_done;
    logic found;
    logic has_len;
  } sts_t;

endpackage

FILE: rtl/cidat_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module cidat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/cidat_div.sv
// Restoring divider, one quotient bit per cycle, for the rate tick.
// Depends on cidat_pkg.
module cidat_div import cidat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivBits-1:0] dividend_i,
  input  logic [31:0]        divisor_i,
  output logic               done_o,
  output logic [31:0]        quot_o
);
  logic [DivBits-1:0] q_q, q_d;
  logic [32:0]        r_q, r_d;
  logic [31:0]        dv_q, dv_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [33:0]        trial;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    dv_d = dv_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {r_q, q_q[DivBits-1]} - {2'b0, dv_q};
    if (start_i) begin
      q_d = dividend_i;
      r_d = '0;
      dv_d = divisor_i;
      cnt_d = 6'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        r_d = trial[32:0];
        q_d = {q_q[DivBits-2:0], 1'b1};
      end else begin
        r_d = {r_q[31:0], q_q[DivBits-1]};
        q_d = {q_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    dv_q <= dv_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quot_o = q_q[31:0];
endmodule

FILE: rtl/cidat_datapath.sv
// Datapath: entry memories, search index, counters and result register.
// Depends on cidat_pkg, cidat_ram and cidat_div.
module cidat_datapath import cidat_pkg::*; #(
  parameter int unsigned TrackEntries = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic [1:0]  operation_i,
  input  logic [28:0] can_id_i,
  input  logic        extended_i,
  input  logic        frame_known_i,
  input  logic [31:0] now_ms_i,
  input  logic [3:0]  data_len_i,
  input  logic [63:0] frame_bytes_i,
  input  logic [31:0] elapsed_ms_i,
  output logic [2:0]  status_o,
  output logic [4:0]  slot_index_o,
  output logic [63:0] stored_bytes_o,
  output logic [3:0]  stored_len_o,
  output logic [31:0] frame_count_o,
  output logic [31:0] frame_rate_o,
  output logic        entry_known_o,
  output logic [31:0] total_frames_o,
  output logic [31:0] untracked_frames_o
);
  localparam int unsigned IdxW = (TrackEntries > 1) ? $clog2(TrackEntries) : 1;
  localparam int unsigned CntW = $clog2(TrackEntries + 1);
  localparam int unsigned RamD = 1 << IdxW;

  logic [1:0]  op_q;
  logic [28:0] id_q;
  logic        ext_q, known_q;
  logic [31:0] now_q, elapsed_q;
  logic [3:0]  len_q;
  logic [63:0] bytes_q;

  logic [IdxW-1:0] idx_q, idx_d, slot_q, addr;
  logic [CntW-1:0] used_q, used_d;
  logic            match_q;
  logic            full_q;
  logic [31:0]     total_q, total_d, untr_q, untr_d;
  logic [RamD-1:0] len_vld_q;

  // Memory read ports.
  logic [29:0] key_rd;
  logic [31:0] cnt_rd, cat_rd, rate_rd;
  logic        kn_rd;
  logic [63:0] by_rd;
  logic [3:0]  len_rd, len_eff;

  logic        we_key, we_cnt, we_cat, we_rate, we_kn, we_by, we_len;
  logic [31:0] cnt_wd, cat_wd, rate_wd;
  logic [31:0] delta, quot;
  logic [DivBits-1:0] prod;
  logic        div_done;

  logic [2:0]  status_d;
  logic [63:0] sby_d;
  logic [3:0]  slen_d;
  logic [31:0] fc_d, fr_d;
  logic        kn_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      op_q <= operation_i;
      id_q <= can_id_i;
      ext_q <= extended_i;
      known_q <= frame_known_i;
      now_q <= now_ms_i;
      len_q <= (data_len_i > 4'(MaxLen)) ? 4'(MaxLen) : data_len_i;
      bytes_q <= frame_bytes_i;
      elapsed_q <= (elapsed_ms_i == '0) ? 32'd1 : elapsed_ms_i;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.clr_idx) begin
      idx_d = '0;
    end else if (ctl_i.inc_idx) begin
      idx_d = idx_q + 1'b1;
    end
  end

  assign addr = (ctl_i.sel_found || ctl_i.sel_new) ? slot_q : idx_q;

  logic new_entry;
  assign new_entry = !match_q;

  always_comb begin
    used_d = used_q;
    total_d = total_q;
    untr_d = untr_q;
    if (ctl_i.wr_upd) begin
      total_d = total_q + 32'd1;
      if (new_entry) begin
        used_d = used_q + 1'b1;
      end
    end
    if (ctl_i.out_load && status_d == ST_FULL) begin
      total_d = total_q + 32'd1;
      untr_d = untr_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      used_q <= '0;
      total_q <= '0;
      untr_q <= '0;
      match_q <= 1'b0;
      full_q <= 1'b0;
      slot_q <= '0;
      len_vld_q <= '0;
    end else begin
      idx_q <= idx_d;
      used_q <= used_d;
      total_q <= total_d;
      untr_q <= untr_d;
      if (ctl_i.clr_idx) begin
        match_q <= 1'b0;
      end else if (ctl_i.cap_match && !match_q && key_rd == {ext_q, id_q}) begin
        match_q <= 1'b1;
        slot_q <= idx_q;
      end
      if (ctl_i.sel_new && ctl_i.rd_en) begin
        slot_q <= used_q[IdxW-1:0];
      end
      // The table state seen at the decision sets a dropped frame apart from an add.
      if (ctl_i.rd_en) begin
        full_q <= (used_q == CntW'(TrackEntries));
      end
      if (we_len) begin
        len_vld_q[addr] <= 1'b1;
      end
    end
  end

  assign we_key  = ctl_i.wr_upd && new_entry;
  assign we_cnt  = ctl_i.wr_upd;
  assign we_cat  = (ctl_i.wr_upd && new_entry) || ctl_i.wr_tick;
  assign we_rate = (ctl_i.wr_upd && new_entry) || ctl_i.wr_tick;
  assign we_kn   = ctl_i.wr_upd;
  assign we_by   = ctl_i.wr_upd && op_q == OP_OBSERVE;
  assign we_len  = we_by;

  assign cnt_wd  = new_entry ? 32'd1 : cnt_rd + 32'd1;
  assign cat_wd  = ctl_i.wr_tick ? cnt_rd : 32'd0;
  assign rate_wd = ctl_i.wr_tick ? quot : 32'd0;

  cidat_ram #(.Width(30), .Depth(RamD)) u_key (
    .clk_i, .we_i(we_key), .addr_i(addr), .wdata_i({ext_q, id_q}), .rdata_o(key_rd));
  cidat_ram #(.Width(32), .Depth(RamD)) u_cnt (
    .clk_i, .we_i(we_cnt), .addr_i(addr), .wdata_i(cnt_wd), .rdata_o(cnt_rd));
  cidat_ram #(.Width(32), .Depth(RamD)) u_cat (
    .clk_i, .we_i(we_cat), .addr_i(addr), .wdata_i(cat_wd), .rdata_o(cat_rd));
  cidat_ram #(.Width(32), .Depth(RamD)) u_rate (
    .clk_i, .we_i(we_rate), .addr_i(addr), .wdata_i(rate_wd), .rdata_o(rate_rd));
  cidat_ram #(.Width(1), .Depth(RamD)) u_kn (
    .clk_i, .we_i(we_kn), .addr_i(addr), .wdata_i(known_q), .rdata_o(kn_rd));
  cidat_ram #(.Width(64), .Depth(RamD)) u_by (
    .clk_i, .we_i(we_by), .addr_i(addr), .wdata_i(bytes_q), .rdata_o(by_rd));
  cidat_ram #(.Width(4), .Depth(RamD)) u_len (
    .clk_i, .we_i(we_len), .addr_i(addr), .wdata_i(len_q), .rdata_o(len_rd));

  logic vld_rd_q;
  always_ff @(posedge clk_i) begin
    vld_rd_q <= len_vld_q[addr];
  end
  assign len_eff = vld_rd_q ? len_rd : 4'd0;

  // The entry read is valid in the cycle the divider loads, so the product feeds it directly.
  assign delta = cnt_rd - cat_rd;
  assign prod = DivBits'(delta) * DivBits'(RateScale);

  cidat_div u_div (
    .clk_i, .rst_ni, .start_i(ctl_i.div_start), .dividend_i(prod),
    .divisor_i(elapsed_q), .done_o(div_done), .quot_o(quot));

  // Result selection from the captured operation and the entry read.
  always_comb begin
    status_d = ST_TICK_DONE;
    sby_d = '0;
    slen_d = '0;
    fc_d = '0;
    fr_d = '0;
    kn_d = 1'b0;
    case (op_q)
      OP_OBSERVE, OP_NOTE: begin
        if (!match_q && full_q) begin
          status_d = ST_FULL;
        end else begin
          status_d = match_q ? ST_HIT : ST_ADDED;
          fc_d = cnt_rd;
          fr_d = rate_rd;
          kn_d = kn_rd;
        end
      end
      OP_QUERY: begin
        if (match_q && len_eff != 4'd0) begin
          status_d = ST_FOUND;
          sby_d = by_rd;
          slen_d = len_eff;
          fc_d = cnt_rd;
          fr_d = rate_rd;
          kn_d = kn_rd;
        end else begin
          status_d = ST_QMISS;
        end
      end
      default: status_d = ST_TICK_DONE;
    endcase
  end

  logic show_slot;
  assign show_slot = (status_d == ST_HIT) || (status_d == ST_ADDED) || (status_d == ST_FOUND);

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_o <= status_d;
      slot_index_o <= show_slot ? 5'(slot_q) : 5'd0;
      stored_bytes_o <= sby_d;
      stored_len_o <= slen_d;
      frame_count_o <= fc_d;
      frame_rate_o <= fr_d;
      entry_known_o <= kn_d;
      total_frames_o <= total_d;
      untracked_frames_o <= untr_d;
    end
  end

  assign sts_o.match = match_q;
  assign sts_o.idx_last = (idx_q == IdxW'(TrackEntries - 1));
  assign sts_o.idx_at_used = (CntW'(idx_q) >= used_q);
  assign sts_o.full = (used_q == CntW'(TrackEntries));
  assign sts_o.div_done = div_done;
  assign sts_o.found = match_q;
  assign sts_o.has_len = ctl_i.resp_cap && (len_eff != 4'd0);
endmodule

FILE: rtl/cidat_ctrl.sv
// Controller state machine sequencing search, update, tick and response.
// Depends on cidat_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cidat_ctrl import cidat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [1:0] operation_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);
  state_e state_q, state_d;
  logic   is_tick_q, is_tick_d, is_upd_q, is_upd_d;
  logic   ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    is_tick_d = is_tick_q;
    is_upd_d = is_upd_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          is_tick_d = (operation_i == OP_TICK);
          is_upd_d = (operation_i == OP_OBSERVE) || (operation_i == OP_NOTE);
          state_d = (operation_i == OP_TICK) ? S_TICK_RD : S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_d = sts_i.idx_at_used ? S_DECIDE : S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sts_i.idx_last) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_DECIDE: begin
        if (is_upd_q && (sts_i.found || !sts_i.full)) begin
          state_d = S_UPD;
        end else begin
          state_d = S_RESP_RD;
        end
      end
      S_UPD: state_d = S_RESP_RD;
      // The result register is loaded in S_RESP only once the previous result has left.
      S_RESP_RD: begin
        if (!ovld_q || out_ready_i) begin
          state_d = S_RESP;
        end
      end
      S_RESP: state_d = S_OUT;
      S_TICK_RD: state_d = sts_i.idx_at_used ? S_OUT : S_TICK_DIV;
      S_TICK_DIV: state_d = S_TICK_WR;
      S_TICK_WR: begin
        if (sts_i.div_done) begin
          state_d = sts_i.idx_last ? S_OUT : S_TICK_RD;
        end
      end
      S_OUT: begin
        if (!ovld_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      S_IDLE: begin
        ctl_o.ld_in = in_valid_i && in_ready_o;
        ctl_o.clr_idx = 1'b1;
      end
      S_SRCH_CMP: begin
        ctl_o.cap_match = 1'b1;
        ctl_o.inc_idx = 1'b1;
      end
      S_DECIDE: begin
        ctl_o.sel_found = sts_i.found;
        ctl_o.sel_new = !sts_i.found;
        ctl_o.rd_en = 1'b1;
      end
      S_UPD: begin
        ctl_o.sel_found = 1'b1;
        ctl_o.wr_upd = 1'b1;
      end
      S_RESP_RD: ctl_o.sel_found = 1'b1;
      S_RESP: begin
        ctl_o.sel_found = 1'b1;
        ctl_o.resp_cap = 1'b1;
        ctl_o.out_load = 1'b1;
      end
      S_TICK_DIV: ctl_o.div_start = 1'b1;
      S_TICK_WR: begin
        ctl_o.wr_tick = sts_i.div_done;
        ctl_o.inc_idx = sts_i.div_done;
      end
      S_OUT: ctl_o.out_load = is_tick_q && (!ovld_q || out_ready_i);
      default: ctl_o = '0;
    endcase
  end

  // S_OUT loads the result for tick items; all others load in S_RESP.
  logic s_out_take;
  assign s_out_take = (state_q == S_OUT) && (!ovld_q || out_ready_i);

  always_comb begin
    ovld_d = ovld_q;
    if (out_valid_o && out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (s_out_take) begin
      ovld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      is_tick_q <= 1'b0;
      is_upd_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      is_tick_q <= is_tick_d;
      is_upd_q <= is_upd_d;
      ovld_q <= ovld_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_take_sets_valid, clk_i, rst_ni, s_out_take, out_valid_o, "result not shown")
  `ASSERT_IMPL(a_no_clash, clk_i, rst_ni, ctl_o.wr_upd, !ctl_o.wr_tick, "update and tick write")
endmodule

FILE: rtl/can_id_activity_table.sv
// Top level of the CAN identifier activity table.
// Depends on cidat_pkg, cidat_ctrl and cidat_datapath.
//
//  Channel  Handshake                     Payload
//  in       in_valid_i / in_ready_o       operation_i .. elapsed_ms_i
//  out      out_valid_o / out_ready_i     status_o .. untracked_frames_o
//
// A frame reads and compares each used entry in turn, then updates its entry; queries
// and dropped frames skip the update. A full table is searched through its last entry.
// A tick reads each used entry, runs the bit-serial divider on it and writes the rate back.
// Reset clears counters, length valid bits and control; entry memories need no clearing pass.
// The next item is taken once the result is loaded into the output register; a result
// still waiting there holds the following item just before its response is loaded.
module can_id_activity_table import cidat_pkg::*; #(
  parameter int unsigned TRACK_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [28:0] can_id_i,
  input  logic        extended_i,
  input  logic        frame_known_i,
  input  logic [31:0] now_ms_i,
  input  logic [3:0]  data_len_i,
  input  logic [63:0] frame_bytes_i,
  input  logic [31:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [4:0]  slot_index_o,
  output logic [63:0] stored_bytes_o,
  output logic [3:0]  stored_len_o,
  output logic [31:0] frame_count_o,
  output logic [31:0] frame_rate_o,
  output logic        entry_known_o,
  output logic [31:0] total_frames_o,
  output logic [31:0] untracked_frames_o
);
  ctl_t ctl;
  sts_t sts;

  cidat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .operation_i, .sts_i(sts), .ctl_o(ctl));

  cidat_datapath #(.TrackEntries(TRACK_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .operation_i, .can_id_i, .extended_i, .frame_known_i, .now_ms_i,
    .data_len_i, .frame_bytes_i, .elapsed_ms_i,
    .status_o, .slot_index_o, .stored_bytes_o, .stored_len_o, .frame_count_o,
    .frame_rate_o, .entry_known_o, .total_frames_o, .untracked_frames_o);
endmodule
